// ===== rtl/utf8wt_pkg.sv =====
// shared types and constants for the utf-8 width truncation unit
`default_nettype none
package utf8wt_pkg;

  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 12;
  localparam int SUM_W       = 14;
  localparam int BURST_MAX   = 4;
  localparam int BURST_CNT_W = 3;
  localparam int OBUF_DEPTH  = 8;
  localparam int OBUF_PTR_W  = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W  = $clog2(OBUF_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd64;
  localparam logic [BYTE_W-1:0]  DOT_BYTE    = 8'h2E;
  localparam logic [BYTE_W-1:0]  ASCII_MAX   = 8'h7F;

  typedef struct packed {
    logic [BURST_CNT_W-1:0]           cnt;
    logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
    logic [BURST_MAX-1:0]             lasts;
  } burst_t;

endpackage
`default_nettype wire

// ===== rtl/utf8_width_truncate_unit.sv =====
// top level of the utf-8 display width truncation unit
// input: an accepted byte is held in the input register until the queue has room
//   for a full burst, then its burst is written into the output queue
// throughput: one input byte per cycle while the queue has room for a full
//   burst (four bytes); output drains one byte per cycle while out_ready is high, from an eight-entry queue
// reset: synchronous active-low rst_n clears string state, input register, queue and sets the width limit to 64
`default_nettype none
module utf8_width_truncate_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [utf8wt_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [utf8wt_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [utf8wt_pkg::BYTE_W-1:0]       out_byte,
  output logic                                out_last
);
  import utf8wt_pkg::*;

  logic              item_v_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic              item_last_r;
  logic              space;
  logic              go;
  burst_t            burst;

  assign go       = item_v_r && space;
  assign in_ready = !item_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
  end

  utf8wt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item_byte (item_byte_r),
    .item_last (item_last_r),
    .burst     (burst)
  );

  utf8wt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && !space) |=> (item_v_r && $stable(item_byte_r) && $stable(item_last_r)))
    else $error("held transaction lost while queue full");

endmodule
`default_nettype wire

// ===== rtl/utf8wt_core.sv =====
// decode and width state: turns one registered byte into a burst of output bytes
`default_nettype none
module utf8wt_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [utf8wt_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire logic                           go,
  input  wire logic [utf8wt_pkg::BYTE_W-1:0]  item_byte,
  input  wire logic                           item_last,
  output utf8wt_pkg::burst_t                  burst
);
  import utf8wt_pkg::*;

  logic [LIMIT_W-1:0]  limit_r;
  logic [2:0][BYTE_W-1:0] pend_r, pend_nxt;
  logic [1:0]          pcnt_r, pcnt_nxt;
  logic [1:0]          need_r, need_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                stop_r, stop_nxt;
  logic [SUM_W-1:0]    limit2;

  assign limit2 = {1'b0, limit_r, 1'b0};

  always_comb begin
    logic [SUM_W-1:0] s;
    logic             cut;
    logic             done_char;
    s         = '0;
    cut       = 1'b0;
    done_char = 1'b0;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    need_nxt  = need_r;
    sum_nxt   = sum_r;
    stop_nxt  = stop_r;
    burst     = '0;
    if (go) begin
      if (stop_r) begin
        if (item_last) begin
          cut = 1'b1;
        end
      end else if (need_r == 2'd0) begin
        if (item_byte <= ASCII_MAX) begin
          burst.cnt      = BURST_CNT_W'(1);
          burst.bytes[0] = item_byte;
          burst.lasts[0] = item_last;
          s              = sum_r + SUM_W'(1);
          done_char      = 1'b1;
        end else if (item_byte[7:5] == 3'b110 || item_byte[7:4] == 4'b1110 ||
                     item_byte[7:3] == 5'b11110) begin
          if (item_last) begin
            cut = 1'b1;
          end else begin
            pend_nxt[0] = item_byte;
            pcnt_nxt    = 2'd1;
            if (item_byte[7:5] == 3'b110) begin
              need_nxt = 2'd1;
            end else if (item_byte[7:4] == 4'b1110) begin
              need_nxt = 2'd2;
            end else begin
              need_nxt = 2'd3;
            end
          end
        end else begin
          cut = 1'b1;
        end
      end else if (item_byte[7:6] != 2'b10) begin
        cut = 1'b1;
      end else if (need_r == 2'd1) begin
        for (int k = 0; k < BURST_MAX; k++) begin
          if (k < int'(pcnt_r)) begin
            burst.bytes[k] = pend_r[k];
          end else if (k == int'(pcnt_r)) begin
            burst.bytes[k] = item_byte;
            burst.lasts[k] = item_last;
          end
        end
        burst.cnt = BURST_CNT_W'(pcnt_r) + BURST_CNT_W'(1);
        pcnt_nxt  = 2'd0;
        need_nxt  = 2'd0;
        s         = sum_r + SUM_W'(2);
        done_char = 1'b1;
      end else if (item_last || pcnt_r == 2'd3) begin
        cut = 1'b1;
      end else begin
        pend_nxt[pcnt_r] = item_byte;
        pcnt_nxt         = pcnt_r + 2'd1;
        need_nxt         = need_r - 2'd1;
      end

      if (done_char) begin
        sum_nxt = s;
        if (item_last) begin
          sum_nxt  = '0;
          stop_nxt = 1'b0;
        end else if (s >= limit2) begin
          stop_nxt = 1'b1;
        end
      end

      if (cut) begin
        pcnt_nxt = 2'd0;
        need_nxt = 2'd0;
        if (item_last) begin
          burst.cnt      = BURST_CNT_W'(3);
          burst.bytes[0] = DOT_BYTE;
          burst.bytes[1] = DOT_BYTE;
          burst.bytes[2] = DOT_BYTE;
          burst.lasts    = 4'b0100;
          sum_nxt        = '0;
          stop_nxt       = 1'b0;
        end else begin
          stop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      pcnt_r  <= 2'd0;
      need_r  <= 2'd0;
      sum_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      pcnt_r <= pcnt_nxt;
      need_r <= need_nxt;
      sum_r  <= sum_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // held byte count tracks missing continuation count
  a_pend_need: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r == 2'd0) == (need_r == 2'd0))
    else $error("held bytes and needed bytes disagree");

  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> (need_r == 2'd0))
    else $error("sequence held while stopped");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item_last) |=> (sum_r == '0 && !stop_r && need_r == 2'd0))
    else $error("string state not cleared after final byte");

endmodule
`default_nettype wire

// ===== rtl/utf8wt_obuf.sv =====
// output byte queue: takes a burst of up to four bytes, gives one per cycle while out_ready is high
`default_nettype none
module utf8wt_obuf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire utf8wt_pkg::burst_t            burst,
  output logic                               space,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [utf8wt_pkg::BYTE_W-1:0]      out_byte,
  output logic                               out_last
);
  import utf8wt_pkg::*;

  logic [OBUF_DEPTH-1:0][BYTE_W-1:0] mem_r;
  logic [OBUF_DEPTH-1:0]             lmem_r;
  logic [OBUF_PTR_W-1:0]             rd_r, rd_nxt;
  logic [OBUF_PTR_W-1:0]             wr_r, wr_nxt;
  logic [OBUF_CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                              pop;

  assign space     = cnt_r <= OBUF_CNT_W'(OBUF_DEPTH - BURST_MAX);
  assign out_valid = cnt_r != '0;
  assign out_byte  = mem_r[rd_r];
  assign out_last  = lmem_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    rd_nxt  = pop ? rd_r + OBUF_PTR_W'(1) : rd_r;
    wr_nxt  = wr_r + OBUF_PTR_W'(burst.cnt);
    cnt_nxt = cnt_r + OBUF_CNT_W'(burst.cnt) - OBUF_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BURST_MAX; k++) begin
      if (k < int'(burst.cnt)) begin
        mem_r[wr_r + OBUF_PTR_W'(k)]  <= burst.bytes[k];
        lmem_r[wr_r + OBUF_PTR_W'(k)] <= burst.lasts[k];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (burst.cnt != '0) |-> space)
    else $error("burst written without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OBUF_CNT_W'(OBUF_DEPTH))
    else $error("queue count past depth");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the utf-8 display width truncation unit
`timescale 1ns / 1ps
module testbench;
  import utf8wt_pkg::*;

  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;
  localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
  localparam logic [BYTE_W-1:0] BAD_MIN   = 8'hF8;
  localparam logic [BYTE_W-1:0] BAD_MAX   = 8'hFF;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } text_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;

  text_byte_t pending_inputs[$];
  text_byte_t expected_out[$];
  int         items_queued = 0;
  int         mismatch_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  logic       receiver_hold = 1'b0;
  event       start_hold;

  // width truncation state as the block should hold it
  logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
  logic [BYTE_W-1:0]  held_bytes [3];
  logic [1:0]         held_count = '0;
  logic [1:0]         cont_needed = '0;
  logic [SUM_W-1:0]   half_sum = '0;
  logic               cut_off = 1'b0;

  always #5 clk = ~clk;

  utf8_width_truncate_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic expect_byte(input logic [BYTE_W-1:0] b, input logic fin);
    text_byte_t t;
    t.data = b;
    t.last = fin;
    expected_out.push_back(t);
  endtask

  task automatic expect_ellipsis();
    expect_byte(DOT_BYTE, 1'b0);
    expect_byte(DOT_BYTE, 1'b0);
    expect_byte(DOT_BYTE, 1'b1);
  endtask

  task automatic reset_string();
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    held_bytes[2] = '0;
    held_count = '0;
    cont_needed = '0;
    half_sum = '0;
    cut_off = 1'b0;
  endtask

  task automatic cut_string(input logic fin);
    held_count = '0;
    cont_needed = '0;
    if (fin) begin
      expect_ellipsis();
      reset_string();
    end else begin
      cut_off = 1'b1;
    end
  endtask

  task automatic close_char(input logic fin);
    if (fin) begin
      reset_string();
    end else if (half_sum >= {limit_model, 1'b0}) begin
      cut_off = 1'b1;
    end
  endtask

  task automatic truncate_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic [1:0] lead_need;
    if (cut_off) begin
      if (fin) begin
        expect_ellipsis();
        reset_string();
      end
    end else if (cont_needed == 2'd0) begin
      if (b <= ASCII_MAX) begin
        expect_byte(b, fin);
        half_sum += 1;
        close_char(fin);
      end else begin
        if (b >= LEAD2_MIN && b <= LEAD2_MAX) lead_need = 2'd1;
        else if (b >= LEAD3_MIN && b <= LEAD3_MAX) lead_need = 2'd2;
        else if (b >= LEAD4_MIN && b <= LEAD4_MAX) lead_need = 2'd3;
        else lead_need = 2'd0;
        if (lead_need == 2'd0 || fin) begin
          cut_string(fin);
        end else begin
          held_bytes[0] = b;
          held_count = 2'd1;
          cont_needed = lead_need;
        end
      end
    end else if (b < CONT_MIN || b > CONT_MAX) begin
      cut_string(fin);
    end else if (cont_needed == 2'd1) begin
      for (int k = 0; k < held_count; k++) expect_byte(held_bytes[k], 1'b0);
      expect_byte(b, fin);
      held_count = '0;
      cont_needed = '0;
      half_sum += 2;
      close_char(fin);
    end else if (fin || held_count == 2'd3) begin
      cut_string(fin);
    end else begin
      held_bytes[held_count] = b;
      held_count++;
      cont_needed--;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) truncate_byte(in_byte, in_last);
      if (!in_valid || in_ready) begin
        if (pending_inputs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= pending_inputs[0].data;
          in_last  <= pending_inputs[0].last;
          void'(pending_inputs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction byte %h last %b",
                                    out_byte, out_last));
        end else begin
          if (out_byte !== expected_out[0].data)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_byte, expected_out[0].data));
          if (out_last !== expected_out[0].last)
            report_mismatch($sformatf("out_last %b, expected %b",
                                      out_last, expected_out[0].last));
          void'(expected_out.pop_front());
        end
      end
      out_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    @(start_hold);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_item(input logic [BYTE_W-1:0] b, input logic fin);
    text_byte_t t;
    t.data = b;
    t.last = fin;
    pending_inputs.push_back(t);
    items_queued++;
  endtask

  task automatic add_sequence(ref logic [BYTE_W-1:0] seq[$], input int len,
                              input int conts);
    case (len)
      2: seq.push_back(BYTE_W'($urandom_range(LEAD2_MAX, LEAD2_MIN)));
      3: seq.push_back(BYTE_W'($urandom_range(LEAD3_MAX, LEAD3_MIN)));
      default: seq.push_back(BYTE_W'($urandom_range(LEAD4_MAX, LEAD4_MIN)));
    endcase
    repeat (conts) seq.push_back(BYTE_W'($urandom_range(CONT_MAX, CONT_MIN)));
  endtask

  task automatic queue_string(input int max_chars);
    logic [BYTE_W-1:0] seq[$];
    int kind;
    int len;
    repeat ($urandom_range(max_chars, 1)) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        seq.push_back(BYTE_W'($urandom_range(ASCII_MAX)));
      end else if (kind < 76) begin
        len = (kind < 52) ? 2 : (kind < 64) ? 3 : 4;
        add_sequence(seq, len, len - 1);
      end else if (kind < 83) begin
        if ($urandom_range(1)) seq.push_back(BYTE_W'($urandom_range(CONT_MAX, CONT_MIN)));
        else seq.push_back(BYTE_W'($urandom_range(BAD_MAX, BAD_MIN)));
      end else if (kind < 90) begin
        // sequence broken by a byte that is not a continuation
        len = $urandom_range(4, 2);
        add_sequence(seq, len, $urandom_range(len - 2));
        if ($urandom_range(1)) seq.push_back(BYTE_W'($urandom_range(ASCII_MAX)));
        else seq.push_back(BYTE_W'($urandom_range(BAD_MAX, LEAD2_MIN)));
      end else begin
        seq.push_back(BYTE_W'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(4, 2);
      add_sequence(seq, len, $urandom_range(len - 2));
    end
    foreach (seq[i]) queue_item(seq[i], i == seq.size() - 1);
  endtask

  task automatic wait_for_idle();
    while (pending_inputs.size() != 0 || in_valid || expected_out.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    limit_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings under the reset limit
    queue_item(8'h00, 1'b0);
    queue_item(ASCII_MAX, 1'b0);
    queue_item(8'hC3, 1'b0);
    queue_item(8'hA9, 1'b1);
    queue_item(8'hE2, 1'b0);
    queue_item(8'h82, 1'b0);
    queue_item(8'hAC, 1'b0);
    queue_item(8'hF0, 1'b0);
    queue_item(8'h9F, 1'b0);
    queue_item(8'h98, 1'b0);
    queue_item(8'h80, 1'b1);
    // stray continuation as lead byte
    queue_item(CONT_MIN, 1'b0);
    queue_item(8'h41, 1'b1);
    // invalid lead byte that ends the string
    queue_item(BAD_MAX, 1'b1);
    // broken continuation
    queue_item(8'hC3, 1'b0);
    queue_item(8'h41, 1'b0);
    queue_item(8'h42, 1'b1);
    // incomplete tail
    queue_item(8'hE2, 1'b0);
    queue_item(8'h82, 1'b1);
    queue_item(LEAD4_MAX, 1'b1);
    wait_for_idle();

    // zero limit still keeps the first character
    write_limit('0);
    queue_item(8'h41, 1'b0);
    queue_item(8'h42, 1'b0);
    queue_item(8'h43, 1'b1);
    wait_for_idle();

    // limit met on the final character
    write_limit(12'd1);
    queue_item(8'h61, 1'b0);
    queue_item(8'h62, 1'b1);
    wait_for_idle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      case (p)
        0: write_limit(12'd4095);
        1: write_limit('0);
        2: write_limit(12'd3);
        3: write_limit(12'd5);
        4: write_limit(LIMIT_RESET);
        5: write_limit(12'd2);
        6: write_limit(12'd1);
        default: write_limit(LIMIT_W'($urandom_range(12)));
      endcase
      target = items_queued + 16;
      while (items_queued < target) queue_string((p % 2 == 1) ? 4 : 10);
      if (p % 3 == 1) begin
        // leave the string open with a sequence held across the limit write
        queue_item(BYTE_W'($urandom_range(ASCII_MAX)), 1'b0);
        queue_item(LEAD3_MIN, 1'b0);
        queue_item(CONT_MAX, 1'b0);
      end
      wait_for_idle();
    end

    // backpressure: receiver held off while the sender keeps offering
    write_limit(12'd4095);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    -> start_hold;
    target = items_queued + 30;
    while (items_queued < target) queue_string(6);
    queue_item(8'h7A, 1'b1);
    wait_for_idle();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/utf8wt_pkg.sv
rtl/utf8wt_core.sv
rtl/utf8wt_obuf.sv
rtl/utf8_width_truncate_unit.sv
tb/testbench.sv
